FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent assertions used in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mmpf_pkg.sv
// ---------------------------------------------------------------------------
// mmpf_pkg
// Sizes, types and constants of the multichannel median knob filter.
// ---------------------------------------------------------------------------
package mmpf_pkg;

	localparam int NUM_CHANNELS = 10;
	localparam int WINDOW_SIZE  = 5;
	localparam int SAMPLE_BITS  = 12;

	localparam int SAMPLE_W  = 12;
	localparam int CHANNEL_W = 4;
	localparam int THRESH_W  = 12;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd8;

	localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int SLOT_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int CNT_W   = $clog2(WINDOW_SIZE + 1);
	localparam int WORDS   = NUM_CHANNELS * WINDOW_SIZE;
	localparam int ADDR_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CMP_W   = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

	typedef logic [SAMPLE_BITS-1:0] word_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		word_t             held;
	} chan_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CHAN = 4'b0010,
		ST_READ = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

endpackage

FILE: rtl/multichannel_median_pot_filter.sv
// ---------------------------------------------------------------------------
// multichannel_median_pot_filter
// Round-robin running median filter with a deadband for scanned knobs.
// ---------------------------------------------------------------------------
// Each request carries one sample for the next channel of the scan; after
// acceptance it passes through ST_CHAN, ST_READ and ST_FIN and reaches the
// result register once the result side is free; the next request can be taken
// only after the return to ST_IDLE, so requests never overlap. The
// window is fetched from the sample memory through its single read port, one
// word per cycle, and ranked as the words arrive. A new request is taken once
// the previous result has been loaded, even while that result is still
// stalled. Clearing at reset is done by valid bits, so there is no clearing
// pass after reset.
`include "assert_macros.svh"

module multichannel_median_pot_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mmpf_pkg::THRESH_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mmpf_pkg::SAMPLE_W-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mmpf_pkg::CHANNEL_W-1:0] channel,
	output logic [mmpf_pkg::SAMPLE_W-1:0] median_value,
	output logic [mmpf_pkg::SAMPLE_W-1:0] held_value,
	output logic                          changed
);
	import mmpf_pkg::*;

	localparam logic [SLOT_W-1:0] MID_RANK  = SLOT_W'(WINDOW_SIZE / 2);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SIZE - 1);
	localparam logic [CH_W-1:0]   LAST_CH   = CH_W'(NUM_CHANNELS - 1);

	state_t                state_q;
	logic [THRESH_W-1:0]   thresh_q;
	logic [CH_W-1:0]       scan_q;
	logic [CH_W-1:0]       next_ch;
	word_t                 sample_q;
	logic [SLOT_W-1:0]     slot_q;
	word_t                 held_old_q;
	logic [SLOT_W-1:0]     rk_q;

	chan_entry_t           chan_mem [NUM_CHANNELS];
	chan_entry_t           chan_rdata_q;
	logic                  chan_rvld_q;
	logic [NUM_CHANNELS-1:0] chan_vld_q;
	logic                  chan_we;
	chan_entry_t           chan_wdata;

	word_t                 win_mem [WORDS];
	word_t                 win_rdata_q;
	logic                  win_rvld_q;
	logic [WORDS-1:0]      win_vld_q;
	logic                  win_we;
	logic [ADDR_W-1:0]     win_waddr;
	logic [ADDR_W-1:0]     win_raddr;
	logic [ADDR_W-1:0]     base_addr;
	logic [CNT_W-1:0]      issue_k;

	word_t                 win_q  [WINDOW_SIZE];
	logic [SLOT_W-1:0]     rank_q [WINDOW_SIZE];

	logic [SLOT_W-1:0]     slot_cur;
	logic [SLOT_W-1:0]     slot_new;
	word_t                 elem;
	logic [SLOT_W-1:0]     le_cnt;
	word_t                 med;
	word_t                 diff;
	logic                  upd;
	word_t                 held_new;
	logic                  in_accept;
	logic                  out_free;
	logic                  load_out;

	logic [CHANNEL_W-1:0]  channel_q;
	logic [SAMPLE_W-1:0]   median_q;
	logic [SAMPLE_W-1:0]   held_q;
	logic                  changed_q;
	logic                  out_valid_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign load_out  = (state_q == ST_FIN) && out_free;

	assign next_ch = (scan_q == LAST_CH) ? '0 : scan_q + CH_W'(1);

	always_comb begin
		slot_cur = chan_rvld_q ? chan_rdata_q.slot : '0;
		slot_new = (slot_cur != LAST_SLOT) ? slot_cur + SLOT_W'(1) : '0;
	end

	assign base_addr = ADDR_W'(scan_q) * ADDR_W'(WINDOW_SIZE);
	assign win_waddr = base_addr + ADDR_W'(slot_new);
	assign win_we    = (state_q == ST_CHAN);

	always_comb begin
		issue_k = (state_q == ST_CHAN) ? '0 : CNT_W'(rk_q) + CNT_W'(1);
		if (issue_k >= CNT_W'(WINDOW_SIZE)) begin
			issue_k = '0;
		end
		win_raddr = base_addr + ADDR_W'(issue_k);
	end

	always_comb begin
		if (rk_q == slot_q) begin
			elem = sample_q;
		end else if (win_rvld_q) begin
			elem = win_rdata_q;
		end else begin
			elem = '0;
		end
		le_cnt = '0;
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			if (SLOT_W'(i) < rk_q && win_q[i] <= elem) begin
				le_cnt = le_cnt + SLOT_W'(1);
			end
		end
	end

	always_comb begin
		med = '0;
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			if (rank_q[i] == MID_RANK) begin
				med = win_q[i];
			end
		end
		diff     = (med >= held_old_q) ? med - held_old_q : held_old_q - med;
		upd      = CMP_W'(diff) >= CMP_W'(thresh_q);
		held_new = upd ? med : held_old_q;
	end

	assign chan_we    = load_out;
	assign chan_wdata = '{slot: slot_q, held: held_new};

	always_ff @(posedge clk) begin
		if (chan_we) begin
			chan_mem[scan_q] <= chan_wdata;
		end
		chan_rdata_q <= chan_mem[next_ch];
	end

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[win_waddr] <= sample_q;
		end
		win_rdata_q <= win_mem[win_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thresh_q    <= THRESH_RESET;
			scan_q      <= '0;
			chan_vld_q  <= '0;
			win_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thresh_q <= cfg_data;
			end
			if (win_we) begin
				win_vld_q[win_waddr] <= 1'b1;
			end
			if (chan_we) begin
				chan_vld_q[scan_q] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						scan_q  <= next_ch;
						state_q <= ST_CHAN;
					end
				end
				ST_CHAN: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					if (rk_q == LAST_SLOT) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		win_rvld_q <= win_vld_q[win_raddr];
		if (in_accept) begin
			sample_q    <= SAMPLE_BITS'(sample);
			chan_rvld_q <= chan_vld_q[next_ch];
		end
		if (state_q == ST_CHAN) begin
			slot_q     <= slot_new;
			held_old_q <= chan_rvld_q ? chan_rdata_q.held : '0;
			rk_q       <= '0;
		end
		if (state_q == ST_READ) begin
			for (int i = 0; i < WINDOW_SIZE; i++) begin
				if (SLOT_W'(i) < rk_q && elem < win_q[i]) begin
					rank_q[i] <= rank_q[i] + SLOT_W'(1);
				end
			end
			rank_q[rk_q] <= le_cnt;
			win_q[rk_q]  <= elem;
			if (rk_q != LAST_SLOT) begin
				rk_q <= rk_q + SLOT_W'(1);
			end
		end
		if (load_out) begin
			channel_q <= CHANNEL_W'(scan_q);
			median_q  <= SAMPLE_W'(med);
			held_q    <= SAMPLE_W'(held_new);
			changed_q <= upd;
		end
	end

	assign out_valid    = out_valid_q;
	assign channel      = channel_q;
	assign median_value = median_q;
	assign held_value   = held_q;
	assign changed      = changed_q;

	`ASSERT_NEXT(a_accept_to_chan, clk, arst_n, in_accept, state_q == ST_CHAN, "request not started")
	`ASSERT_NEXT(a_chan_to_read, clk, arst_n, state_q == ST_CHAN, state_q == ST_READ && rk_q == '0, "window fetch not started")
	`ASSERT_IMPLY(a_changed_held, clk, arst_n, out_valid_q && changed_q, held_q == median_q, "held value differs from median on change")

endmodule
